// ----- rtl/combined_three_lcg_uniform_generator_defines.svh -----
// assertion macros for the combined three-lcg uniform generator checker
// expects signals named clk and rst in the scope of each use
`ifndef COMBINED_THREE_LCG_UNIFORM_GENERATOR_DEFINES_SVH
`define COMBINED_THREE_LCG_UNIFORM_GENERATOR_DEFINES_SVH

// same-cycle implication, off while in reset
`define WH3_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define WH3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// checks what reset leaves behind
`define WH3_ASSERT_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// ----- rtl/wh3_pkg.sv -----
// shared types, constants and arithmetic helpers of the three-lcg generator
// no dependencies
`default_nettype none

package wh3_pkg;

  localparam int unsigned StateW = 15;
  localparam int unsigned SeedW = 31;
  localparam int unsigned FracW = 32;
  localparam int unsigned NumGen = 3;

  typedef logic [StateW-1:0] state_t;

  typedef struct packed {
    state_t first;
    state_t second;
    state_t third;
  } states_t;

  typedef enum logic {
    CMD_DRAW   = 1'b0,
    CMD_RESEED = 1'b1
  } cmd_t;

  // reset values
  localparam state_t ResetFirst = 15'd11;
  localparam state_t ResetSecond = 15'd23;
  localparam state_t ResetThird = 15'd137;

  // moduli and multipliers
  localparam int unsigned ModXVal = 30269;
  localparam int unsigned ModYVal = 30307;
  localparam int unsigned ModZVal = 30323;
  localparam state_t ModX = 15'(ModXVal);
  localparam state_t ModY = 15'(ModYVal);
  localparam state_t ModZ = 15'(ModZVal);
  localparam logic [7:0] MulX = 8'd171;
  localparam logic [7:0] MulY = 8'd172;
  localparam logic [7:0] MulZ = 8'd170;

  // floor(a * 2^16 / m): quotient estimate of a*s/m, low by at most one
  localparam int unsigned StepShift = 16;
  localparam logic [9:0] RecipX = 10'((171 * (1 << StepShift)) / ModXVal);
  localparam logic [9:0] RecipY = 10'((172 * (1 << StepShift)) / ModYVal);
  localparam logic [9:0] RecipZ = 10'((170 * (1 << StepShift)) / ModZVal);

  // reseed: third = 170 * (seed mod 178) + 137
  localparam int unsigned SeedModVal = 178;
  localparam int unsigned SeedFoldVal = (1 << 16) % SeedModVal;
  localparam logic [7:0] SeedMod = 8'(SeedModVal);
  localparam logic [5:0] SeedFold = 6'(SeedFoldVal);
  localparam logic [9:0] SeedRecip = 10'((1 << 17) / SeedModVal);
  localparam logic [7:0] SeedMul = 8'd170;
  localparam state_t SeedOffset = 15'd137;

  // ceil(2^62 / m): floor(v * 2^32 / m) = (v * recip) >> 30 exactly for v < m
  localparam int unsigned FracRecipW = 48;
  localparam int unsigned FracSplit = 24;
  localparam int unsigned FracShift = 30;
  localparam int unsigned ProdW = StateW + FracSplit;
  localparam logic [63:0] FracRecipX64 = ((64'd1 << 62) + 64'(ModXVal) - 64'd1) / 64'(ModXVal);
  localparam logic [63:0] FracRecipY64 = ((64'd1 << 62) + 64'(ModYVal) - 64'd1) / 64'(ModYVal);
  localparam logic [63:0] FracRecipZ64 = ((64'd1 << 62) + 64'(ModZVal) - 64'd1) / 64'(ModZVal);
  localparam logic [NumGen-1:0][FracRecipW-1:0] FracRecip = {
    FracRecipZ64[FracRecipW-1:0],
    FracRecipY64[FracRecipW-1:0],
    FracRecipX64[FracRecipW-1:0]
  };

  // a*s mod m for s < m, constant operands fold into shift-add networks
  function automatic state_t mcg_mulmod(input state_t s, input logic [7:0] mul,
                                        input state_t modulus, input logic [9:0] recip);
    logic [22:0] prod;
    logic [24:0] scaled;
    logic [7:0] quot;
    logic [22:0] rem;
    prod = 23'(mul) * 23'(s);
    scaled = 25'(s) * 25'(recip);
    quot = scaled[StepShift+7:StepShift];
    rem = prod - 23'(quot) * 23'(modulus);
    if (rem >= 23'(modulus)) begin
      rem = rem - 23'(modulus);
    end
    return rem[StateW-1:0];
  endfunction

  // 170 * (seed mod 178) + 137 using 2^16 mod 178 folding
  function automatic state_t reseed_third(input logic [SeedW-1:0] seed);
    logic [20:0] fold1;
    logic [16:0] fold2;
    logic [26:0] scaled;
    logic [16:0] rem;
    fold1 = 21'(seed[SeedW-1:16]) * 21'(SeedFold) + 21'(seed[15:0]);
    fold2 = 17'(fold1[20:16]) * 17'(SeedFold) + 17'(fold1[15:0]);
    scaled = 27'(fold2) * 27'(SeedRecip);
    rem = fold2 - 17'(scaled[26:17]) * 17'(SeedMod);
    if (rem >= 17'(SeedMod)) begin
      rem = rem - 17'(SeedMod);
    end
    return 15'(SeedMul) * 15'(rem[7:0]) + SeedOffset;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/wh3_if.sv -----
// valid/ready channel interfaces for command input and result output
// depends on wh3_pkg
`default_nettype none

interface wh3_in_if;
  logic valid;
  logic ready;
  logic command;
  logic [wh3_pkg::SeedW-1:0] seed;

  modport source (output valid, output command, output seed, input ready);
  modport sink (input valid, input command, input seed, output ready);
endinterface

interface wh3_out_if;
  logic valid;
  logic ready;
  logic [wh3_pkg::FracW-1:0] fraction;
  logic [wh3_pkg::StateW-1:0] first_value;
  logic [wh3_pkg::StateW-1:0] second_value;
  logic [wh3_pkg::StateW-1:0] third_value;

  modport source (output valid, output fraction, output first_value,
                  output second_value, output third_value, input ready);
  modport sink (input valid, input fraction, input first_value,
                input second_value, input third_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/wh3_state.sv -----
// generator state registers with combinational multiply-mod step and reseed
// depends on wh3_pkg
`default_nettype none

module wh3_state (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic                       command,
  input  logic [wh3_pkg::SeedW-1:0]  seed,
  output wh3_pkg::states_t           stepped
);

  wh3_pkg::states_t gen_state;

  always_comb begin
    stepped.first = wh3_pkg::mcg_mulmod(gen_state.first, wh3_pkg::MulX,
                                        wh3_pkg::ModX, wh3_pkg::RecipX);
    stepped.second = wh3_pkg::mcg_mulmod(gen_state.second, wh3_pkg::MulY,
                                         wh3_pkg::ModY, wh3_pkg::RecipY);
    stepped.third = wh3_pkg::mcg_mulmod(gen_state.third, wh3_pkg::MulZ,
                                        wh3_pkg::ModZ, wh3_pkg::RecipZ);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state.first <= wh3_pkg::ResetFirst;
      gen_state.second <= wh3_pkg::ResetSecond;
      gen_state.third <= wh3_pkg::ResetThird;
    end else if (accept) begin
      unique case (wh3_pkg::cmd_t'(command))
        wh3_pkg::CMD_RESEED: gen_state.third <= wh3_pkg::reseed_third(seed);
        wh3_pkg::CMD_DRAW:   gen_state <= stepped;
        default:             gen_state <= gen_state;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wh3_frac_pipe.sv -----
// elastic pipeline that turns new states into the 0.32 fraction
// depends on wh3_pkg and wh3_if
`default_nettype none

module wh3_frac_pipe (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  wh3_pkg::states_t in_states,
  output logic             in_ready,
  wh3_out_if.source        rsp
);

  localparam int unsigned FullW = wh3_pkg::ProdW + wh3_pkg::FracSplit;

  logic stage1_valid;
  logic stage2_valid;
  logic stage3_valid;
  logic out_valid;
  logic en1;
  logic en2;
  logic en3;
  logic en_out;

  wh3_pkg::states_t stage1_states;
  wh3_pkg::states_t stage2_states;
  wh3_pkg::states_t stage3_states;
  wh3_pkg::states_t out_states;

  wh3_pkg::state_t lane [wh3_pkg::NumGen];
  logic [wh3_pkg::ProdW-1:0] prod_hi [wh3_pkg::NumGen];
  logic [wh3_pkg::ProdW-1:0] prod_lo [wh3_pkg::NumGen];
  logic [FullW-1:0] full [wh3_pkg::NumGen];
  logic [wh3_pkg::FracW-1:0] term [wh3_pkg::NumGen];
  logic [wh3_pkg::FracW-1:0] fraction;

  // a stage loads when it is empty or its contents move on
  assign en_out = !out_valid || rsp.ready;
  assign en3 = !stage3_valid || en_out;
  assign en2 = !stage2_valid || en3;
  assign en1 = !stage1_valid || en2;
  assign in_ready = en1;

  always_comb begin
    lane[0] = stage1_states.first;
    lane[1] = stage1_states.second;
    lane[2] = stage1_states.third;
    for (int g = 0; g < wh3_pkg::NumGen; g++) begin
      full[g] = (FullW'(prod_hi[g]) << wh3_pkg::FracSplit) + FullW'(prod_lo[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1_valid <= 1'b0;
      stage2_valid <= 1'b0;
      stage3_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) stage1_valid <= in_valid;
      if (en2) stage2_valid <= stage1_valid;
      if (en3) stage3_valid <= stage2_valid;
      if (en_out) out_valid <= stage3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      stage1_states <= in_states;
    end
    if (en2) begin
      stage2_states <= stage1_states;
      for (int g = 0; g < wh3_pkg::NumGen; g++) begin
        prod_hi[g] <= wh3_pkg::ProdW'(lane[g]) * wh3_pkg::ProdW'(
          wh3_pkg::FracRecip[g][wh3_pkg::FracRecipW-1:wh3_pkg::FracSplit]);
        prod_lo[g] <= wh3_pkg::ProdW'(lane[g]) * wh3_pkg::ProdW'(
          wh3_pkg::FracRecip[g][wh3_pkg::FracSplit-1:0]);
      end
    end
    if (en3) begin
      stage3_states <= stage2_states;
      for (int g = 0; g < wh3_pkg::NumGen; g++) begin
        term[g] <= full[g][wh3_pkg::FracShift+wh3_pkg::FracW-1:wh3_pkg::FracShift];
      end
    end
    if (en_out) begin
      out_states <= stage3_states;
      fraction <= term[0] + term[1] + term[2];
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.fraction = fraction;
  assign rsp.first_value = out_states.first;
  assign rsp.second_value = out_states.second;
  assign rsp.third_value = out_states.third;

endmodule

`default_nettype wire

// ----- rtl/combined_three_lcg_uniform_generator.sv -----
// top level of the combined three-lcg uniform generator
// depends on wh3_pkg, wh3_if, wh3_state and wh3_frac_pipe
//
// usage
//   req (sink): command and seed. command draw advances all three generators
//   and yields one result transaction; command reseed loads the third state
//   with 170 * (seed mod 178) + 137 and yields nothing.
//   rsp (source): fraction as unsigned 0.32, plus the three new states.
// pipeline: an accepted draw is registered in turn as the stepped states,
//   the partial products, the per-generator terms and the sum on rsp.
// throughput: one transaction per cycle on req while req.ready is high, reseeds
//   included; the state registers close a combinational constant multiply-mod loop.
// reset: rst (synchronous, active high) loads the states 11, 23 and 137,
//   empties the pipeline and holds req.ready low.
// stall: while rsp.ready is low the result register holds its transaction;
//   earlier stages keep filling, so req.ready drops only once every stage is
//   full.
`default_nettype none

module combined_three_lcg_uniform_generator (
  input  logic      clk,
  input  logic      rst,
  wh3_in_if.sink    req,
  wh3_out_if.source rsp
);

  logic pipe_ready;
  logic accept;
  logic is_draw;
  wh3_pkg::states_t stepped;

  // every command, draw or reseed, goes through when the first stage can load
  assign req.ready = pipe_ready && !rst;
  assign accept = req.valid && req.ready;
  assign is_draw = (wh3_pkg::cmd_t'(req.command) == wh3_pkg::CMD_DRAW);

  // state registers and their combinational update
  wh3_state u_state (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .command (req.command),
    .seed    (req.seed),
    .stepped (stepped)
  );

  // only draws put a transaction into the fraction pipeline
  wh3_frac_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept && is_draw),
    .in_states (stepped),
    .in_ready  (pipe_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ----- rtl/wh3_checker.sv -----
// port-level assertions for the three-lcg generator, bound to the top level
// depends on wh3_pkg and the defines header
`default_nettype none

`include "combined_three_lcg_uniform_generator_defines.svh"

module wh3_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [wh3_pkg::FracW-1:0]   fraction,
  input logic [wh3_pkg::StateW-1:0]  first_value,
  input logic [wh3_pkg::StateW-1:0]  second_value,
  input logic [wh3_pkg::StateW-1:0]  third_value
);

  // whole result payload, must hold together while stalled
  logic [wh3_pkg::FracW+wh3_pkg::NumGen*wh3_pkg::StateW-1:0] payload;
  logic rsp_stalled;
  logic states_in_range;

  assign payload = {fraction, first_value, second_value, third_value};
  assign rsp_stalled = rsp_valid && !rsp_ready;
  assign states_in_range = first_value != '0 && first_value < wh3_pkg::ModX &&
                           second_value != '0 && second_value < wh3_pkg::ModY &&
                           third_value != '0 && third_value < wh3_pkg::ModZ;

  `WH3_ASSERT_RESET(a_reset_empty, !rsp_valid, "result valid right after reset")
  `WH3_ASSERT_NEXT(a_stall_hold, rsp_stalled, rsp_valid && $stable(payload), "stalled result moved")
  `WH3_ASSERT_NOW(a_backpressure, !req_ready, rsp_stalled, "input stalled without a stalled result")
  `WH3_ASSERT_NOW(a_state_range, rsp_valid, states_in_range, "state out of range")

endmodule

bind combined_three_lcg_uniform_generator wh3_checker u_wh3_checker (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .fraction     (rsp.fraction),
  .first_value  (rsp.first_value),
  .second_value (rsp.second_value),
  .third_value  (rsp.third_value)
);

`default_nettype wire
